FILE: src/chcal_pkg.sv
package chcal_pkg;

    localparam int SAMPLE_W         = 16;
    localparam int DECL_W           = 9;
    localparam int HEAD_W           = 11;
    localparam int SMOOTH_FRAC_BITS = 8;
    localparam int AVG_DIVISOR      = 4;
    localparam int AVG_SHIFT        = $clog2(AVG_DIVISOR);
    localparam int SM_W             = SAMPLE_W + SMOOTH_FRAC_BITS;

    localparam int CORDIC_STEPS     = 16;
    localparam int ITER_W           = $clog2(CORDIC_STEPS);
    localparam int PRESCALE         = 8;
    localparam int CW               = 27;
    localparam int ZW               = 25;
    localparam int AW               = 23;
    localparam int HW               = 27;
    localparam int ANG_FRAC         = 16;
    localparam int QTR_SHIFT        = ANG_FRAC - 2;

    localparam logic [SAMPLE_W-1:0] BOUND_RESET = 16'h8000;
    localparam logic [DECL_W-1:0]   DECL_RESET  = 9'd1;

    localparam logic signed [HW-1:0] DEG_90  = HW'(90  * (2 ** ANG_FRAC));
    localparam logic signed [HW-1:0] DEG_270 = HW'(270 * (2 ** ANG_FRAC));
    localparam logic signed [HW-1:0] DEG_360 = HW'(360 * (2 ** ANG_FRAC));
    localparam logic signed [ZW-1:0] Z_90    = ZW'(90  * (2 ** ANG_FRAC));

    typedef enum logic [8:0] {
        S_IDLE   = 9'b0_0000_0001,
        S_SMOOTH = 9'b0_0000_0010,
        S_BOUND  = 9'b0_0000_0100,
        S_CENTRE = 9'b0_0000_1000,
        S_OFFS   = 9'b0_0001_0000,
        S_CORDIC = 9'b0_0010_0000,
        S_ANGLE  = 9'b0_0100_0000,
        S_DECL   = 9'b0_1000_0000,
        S_WRAP   = 9'b1_0000_0000
    } state_t;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:    v = 25'sd2949120;
            5'd1:    v = 25'sd1740967;
            5'd2:    v = 25'sd919879;
            5'd3:    v = 25'sd466945;
            5'd4:    v = 25'sd234379;
            5'd5:    v = 25'sd117304;
            5'd6:    v = 25'sd58666;
            5'd7:    v = 25'sd29335;
            5'd8:    v = 25'sd14668;
            5'd9:    v = 25'sd7334;
            5'd10:   v = 25'sd3667;
            5'd11:   v = 25'sd1833;
            5'd12:   v = 25'sd917;
            5'd13:   v = 25'sd458;
            5'd14:   v = 25'sd229;
            5'd15:   v = 25'sd115;
            5'd16:   v = 25'sd57;
            5'd17:   v = 25'sd29;
            5'd18:   v = 25'sd14;
            5'd19:   v = 25'sd7;
            5'd20:   v = 25'sd4;
            5'd21:   v = 25'sd2;
            5'd22:   v = 25'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/compass_heading_with_calibration_unit.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+------------------------------------------------
// s_       | s_valid / s_ready  | s_sample_x[15:0], s_sample_y[15:0]
// m_       | m_valid / m_ready  | m_heading_quarter_deg[10:0], m_centre_x, m_centre_y
// cfg_     | cfg_wr_en          | cfg_wr_data[8:0] (declination, signed degrees)
//
// One item at a time, through the 16-step CORDIC loop (one shared shift/add datapath)
// plus smoothing, bounds, centre, offset, angle, declination and wrap steps. An item
// with zero Y offset or zero X offset skips the CORDIC loop. The first item after
// reset only seeds the averages. Reset is synchronous, active low. A finished result
// waits in the output register; the next item is accepted meanwhile and stalls only
// at the wrap step.
module compass_heading_with_calibration_unit
    import chcal_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [SAMPLE_W-1:0]        s_sample_x,
    input  logic [SAMPLE_W-1:0]        s_sample_y,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [HEAD_W-1:0]          m_heading_quarter_deg,
    output logic [SAMPLE_W-1:0]        m_centre_x,
    output logic [SAMPLE_W-1:0]        m_centre_y,
    input  logic                       cfg_wr_en,
    input  logic [DECL_W-1:0]          cfg_wr_data
);

    state_t state_reg, state_next;
    logic   primed_reg, primed_next;
    logic   m_valid_reg, m_valid_next;
    logic [DECL_W-1:0]   decl_reg;
    logic [SAMPLE_W-1:0] max_x_reg, max_x_next, min_x_reg, min_x_next;
    logic [SAMPLE_W-1:0] max_y_reg, max_y_next, min_y_reg, min_y_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;

    logic [SAMPLE_W-1:0] samp_x_reg, samp_x_next, samp_y_reg, samp_y_next;
    logic [SM_W-1:0]     smooth_x_reg, smooth_x_next, smooth_y_reg, smooth_y_next;
    logic [SAMPLE_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic                x_low_reg, x_low_next, y_high_reg, y_high_next;
    logic                y_low_reg, y_low_next;
    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic signed [HW-1:0] h_reg, h_next;
    logic [HEAD_W-1:0]   head_reg, head_next;
    logic [SAMPLE_W-1:0] out_cx_reg, out_cx_next, out_cy_reg, out_cy_next;

    logic [SAMPLE_W-1:0] sx, sy, tx, ty;
    logic                x_low, y_high, y_low;
    logic signed [CW-1:0] dx, dy, y_sh;
    logic                y_lost, y_pos;
    logic [AW-1:0]       angle;
    logic signed [HW-1:0] base, decl_ext, h_wrap;
    logic                out_free;

    assign s_ready               = (state_reg == S_IDLE);
    assign m_valid               = m_valid_reg;
    assign m_heading_quarter_deg = head_reg;
    assign m_centre_x            = out_cx_reg;
    assign m_centre_y            = out_cy_reg;
    assign out_free              = !m_valid_reg || m_ready;

    assign sx     = smooth_x_reg[SM_W-1:SMOOTH_FRAC_BITS];
    assign sy     = smooth_y_reg[SM_W-1:SMOOTH_FRAC_BITS];
    assign x_low  = sx < cx_reg;
    assign y_high = sy > cy_reg;
    assign y_low  = sy < cy_reg;
    assign tx     = x_low ? cx_reg - sx : sx - cx_reg;
    assign ty     = y_low ? cy_reg - sy : sy - cy_reg;

    // shift toward zero; x stays positive through the loop
    assign dx     = x_reg >>> iter_reg;
    assign y_sh   = y_reg >>> iter_reg;
    assign y_lost = |(y_reg & ~({CW{1'b1}} << iter_reg));
    assign dy     = (y_reg[CW-1] && y_lost) ? y_sh + CW'(1) : y_sh;
    assign y_pos  = !y_reg[CW-1] && (y_reg != '0);

    assign angle = z_reg[ZW-1] ? '0 : (z_reg > Z_90 ? AW'(Z_90) : z_reg[AW-1:0]);
    assign base  = x_low_reg ? DEG_90 : DEG_270;

    assign decl_ext = $signed({{(HW-DECL_W-ANG_FRAC){decl_reg[DECL_W-1]}}, decl_reg,
                               {ANG_FRAC{1'b0}}});
    assign h_wrap   = h_reg[HW-1] ? h_reg + DEG_360 :
                      (h_reg >= DEG_360 ? h_reg - DEG_360 : h_reg);

    always_comb begin
        state_next    = state_reg;
        primed_next   = primed_reg;
        m_valid_next  = m_valid_reg;
        max_x_next    = max_x_reg;
        min_x_next    = min_x_reg;
        max_y_next    = max_y_reg;
        min_y_next    = min_y_reg;
        iter_next     = iter_reg;
        samp_x_next   = samp_x_reg;
        samp_y_next   = samp_y_reg;
        smooth_x_next = smooth_x_reg;
        smooth_y_next = smooth_y_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        x_low_next    = x_low_reg;
        y_high_next   = y_high_reg;
        y_low_next    = y_low_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        z_next        = z_reg;
        h_next        = h_reg;
        head_next     = head_reg;
        out_cx_next   = out_cx_reg;
        out_cy_next   = out_cy_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    samp_x_next = s_sample_x;
                    samp_y_next = s_sample_y;
                    state_next  = S_SMOOTH;
                end
            end
            S_SMOOTH: begin
                if (!primed_reg) begin
                    smooth_x_next = {samp_x_reg, {SMOOTH_FRAC_BITS{1'b0}}};
                    smooth_y_next = {samp_y_reg, {SMOOTH_FRAC_BITS{1'b0}}};
                    primed_next   = 1'b1;
                    state_next    = S_IDLE;
                end else begin
                    smooth_x_next = smooth_x_reg - (smooth_x_reg >> AVG_SHIFT)
                        + ({samp_x_reg, {SMOOTH_FRAC_BITS{1'b0}}} >> AVG_SHIFT);
                    smooth_y_next = smooth_y_reg - (smooth_y_reg >> AVG_SHIFT)
                        + ({samp_y_reg, {SMOOTH_FRAC_BITS{1'b0}}} >> AVG_SHIFT);
                    state_next    = S_BOUND;
                end
            end
            S_BOUND: begin
                if (sx > max_x_reg) max_x_next = sx;
                if (sx < min_x_reg) min_x_next = sx;
                if (sy > max_y_reg) max_y_next = sy;
                if (sy < min_y_reg) min_y_next = sy;
                state_next = S_CENTRE;
            end
            S_CENTRE: begin
                cx_next    = (max_x_reg >> 1) + (min_x_reg >> 1);
                cy_next    = (max_y_reg >> 1) + (min_y_reg >> 1);
                state_next = S_OFFS;
            end
            S_OFFS: begin
                x_low_next  = x_low;
                y_high_next = y_high;
                y_low_next  = y_low;
                x_next      = CW'({tx, {PRESCALE{1'b0}}});
                y_next      = CW'({ty, {PRESCALE{1'b0}}});
                iter_next   = '0;
                if (ty == '0) begin
                    z_next     = '0;
                    state_next = S_ANGLE;
                end else if (tx == '0) begin
                    z_next     = Z_90;
                    state_next = S_ANGLE;
                end else begin
                    z_next     = '0;
                    state_next = S_CORDIC;
                end
            end
            S_CORDIC: begin
                if (y_pos) begin
                    x_next = x_reg + dy;
                    y_next = y_reg - dx;
                    z_next = z_reg + atan_entry(5'(iter_reg));
                end else begin
                    x_next = x_reg - dy;
                    y_next = y_reg + dx;
                    z_next = z_reg - atan_entry(5'(iter_reg));
                end
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(CORDIC_STEPS - 1)) begin
                    state_next = S_ANGLE;
                end
            end
            S_ANGLE: begin
                if (x_low_reg ? !y_high_reg : !y_low_reg) begin
                    h_next = base + HW'(angle);
                end else begin
                    h_next = base - HW'(angle);
                end
                state_next = S_DECL;
            end
            S_DECL: begin
                h_next     = h_reg + decl_ext;
                state_next = S_WRAP;
            end
            S_WRAP: begin
                if (out_free) begin
                    head_next    = h_wrap[QTR_SHIFT +: HEAD_W];
                    out_cx_next  = cx_reg;
                    out_cy_next  = cy_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            primed_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
            decl_reg     <= DECL_RESET;
            max_x_reg    <= BOUND_RESET;
            min_x_reg    <= BOUND_RESET;
            max_y_reg    <= BOUND_RESET;
            min_y_reg    <= BOUND_RESET;
            smooth_x_reg <= '0;
            smooth_y_reg <= '0;
            iter_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            primed_reg   <= primed_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                decl_reg <= cfg_wr_data;
            end
            max_x_reg    <= max_x_next;
            min_x_reg    <= min_x_next;
            max_y_reg    <= max_y_next;
            min_y_reg    <= min_y_next;
            smooth_x_reg <= smooth_x_next;
            smooth_y_reg <= smooth_y_next;
            iter_reg     <= iter_next;
        end
    end

    always_ff @(posedge aclk) begin
        samp_x_reg <= samp_x_next;
        samp_y_reg <= samp_y_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        x_low_reg  <= x_low_next;
        y_high_reg <= y_high_next;
        y_low_reg  <= y_low_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        h_reg      <= h_next;
        head_reg   <= head_next;
        out_cx_reg <= out_cx_next;
        out_cy_reg <= out_cy_next;
    end

`ifndef SYNTH
    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (head_reg < HEAD_W'(1440)))
        else $error("heading out of range");

    a_bounds_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (min_x_reg <= max_x_reg) && (min_y_reg <= max_y_reg))
        else $error("min/max window inverted");

    a_cordic_x_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CORDIC) |-> (!x_reg[CW-1] && (x_reg != '0)))
        else $error("CORDIC x not positive");

    a_seed_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !primed_reg) |=> ##1 (state_reg == S_IDLE))
        else $error("seeding item did not return to idle");
`endif

endmodule

FILE: sim/compass_heading_with_calibration_unit_tb.sv
module compass_heading_with_calibration_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import chcal_pkg::*;

    typedef struct packed {
        logic [SAMPLE_W-1:0] x;
        logic [SAMPLE_W-1:0] y;
    } sample_t;

    typedef struct packed {
        logic [HEAD_W-1:0]   heading;
        logic [SAMPLE_W-1:0] cx;
        logic [SAMPLE_W-1:0] cy;
    } heading_t;

    localparam longint ONE_DEG  = 65536;
    localparam longint QTR_DEG  = 16384;
    localparam int     SETTLE   = 40;
    localparam int     PHASE_N  = 190;

    // atan(2^-i) in degrees, 16 fraction bits
    localparam longint ATAN_DEG [16] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    localparam logic [31:0] OPENING [22] = '{
        32'h8000_8000, 32'h8000_8000, 32'h8000_FFFF, 32'hFFFF_8000,
        32'h0000_8000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
        32'hFFFF_0000, 32'h0000_FFFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF,
        32'hAAAA_5555, 32'h5555_AAAA, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'h0000_0000, 32'h0000_0000, 32'h7FFF_8000, 32'h8000_7FFF,
        32'h7FFF_7FFF, 32'h0001_FFFE
    };

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic [SAMPLE_W-1:0] s_sample_x  = '0;
    logic [SAMPLE_W-1:0] s_sample_y  = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic [HEAD_W-1:0]   m_heading_quarter_deg;
    logic [SAMPLE_W-1:0] m_centre_x;
    logic [SAMPLE_W-1:0] m_centre_y;
    logic                cfg_wr_en   = 1'b0;
    logic [DECL_W-1:0]   cfg_wr_data = '0;

    sample_t  pending_samples[$];
    heading_t expected_headings[$];
    int unsigned items_queued = 0;
    int unsigned items_taken  = 0;
    int unsigned mismatch_count = 0;

    // predictor state
    logic [SM_W-1:0]            avg_x, avg_y;
    bit                         seeded = 1'b0;
    logic [SAMPLE_W-1:0]        hi_x = BOUND_RESET, lo_x = BOUND_RESET;
    logic [SAMPLE_W-1:0]        hi_y = BOUND_RESET, lo_y = BOUND_RESET;
    logic signed [DECL_W-1:0]   decl_deg = DECL_RESET;

    int unsigned drv_gap  = 0;
    int unsigned rdy_wait = 0;
    bit          drv_calm = 1'b0;
    bit          rdy_calm = 1'b0;

    compass_heading_with_calibration_unit DUT (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_sample_x            (s_sample_x),
        .s_sample_y            (s_sample_y),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_heading_quarter_deg (m_heading_quarter_deg),
        .m_centre_x            (m_centre_x),
        .m_centre_y            (m_centre_y),
        .cfg_wr_en             (cfg_wr_en),
        .cfg_wr_data           (cfg_wr_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic int unsigned pause_len(input bit calm);
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic logic [SM_W-1:0] ema_update(input logic [SM_W-1:0] avg,
                                                   input logic [SAMPLE_W-1:0] smp);
        return avg - (avg >> AVG_SHIFT) + ((SM_W'(smp) << SMOOTH_FRAC_BITS) >> AVG_SHIFT);
    endfunction

    function automatic longint atan2_deg(input longint tx, input longint ty);
        longint vx, vy, dx, dy, z;
        if (ty == 0) return 0;
        if (tx == 0) return 90 * ONE_DEG;
        vx = tx * 256;
        vy = ty * 256;
        z  = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = vx / (longint'(1) << i);
            dy = vy / (longint'(1) << i);
            if (vy > 0) begin
                vx += dy;
                vy -= dx;
                z  += ATAN_DEG[i];
            end else begin
                vx -= dy;
                vy += dx;
                z  -= ATAN_DEG[i];
            end
        end
        if (z < 0) z = 0;
        if (z > 90 * ONE_DEG) z = 90 * ONE_DEG;
        return z;
    endfunction

    // advance the calibration state by one accepted item, queue its heading unless it only seeds the averages
    task automatic track_sample(input sample_t smp);
        logic [SAMPLE_W-1:0] sx, sy, cx, cy, tx, ty;
        longint ang, hdg;
        heading_t h;
        if (!seeded) begin
            avg_x  = SM_W'(smp.x) << SMOOTH_FRAC_BITS;
            avg_y  = SM_W'(smp.y) << SMOOTH_FRAC_BITS;
            seeded = 1'b1;
        end else begin
            avg_x = ema_update(avg_x, smp.x);
            avg_y = ema_update(avg_y, smp.y);
            sx = SAMPLE_W'(avg_x >> SMOOTH_FRAC_BITS);
            sy = SAMPLE_W'(avg_y >> SMOOTH_FRAC_BITS);
            if (sx > hi_x) hi_x = sx;
            if (sy > hi_y) hi_y = sy;
            if (sx < lo_x) lo_x = sx;
            if (sy < lo_y) lo_y = sy;
            cx = (hi_x >> 1) + (lo_x >> 1);
            cy = (hi_y >> 1) + (lo_y >> 1);
            tx = (sx < cx) ? cx - sx : sx - cx;
            ty = (sy < cy) ? cy - sy : sy - cy;
            ang = atan2_deg(longint'(tx), longint'(ty));
            if (sx < cx)
                hdg = (sy > cy) ? 90 * ONE_DEG - ang : 90 * ONE_DEG + ang;
            else
                hdg = (sy < cy) ? 270 * ONE_DEG - ang : 270 * ONE_DEG + ang;
            hdg = hdg + longint'(decl_deg) * ONE_DEG;
            hdg = hdg % (360 * ONE_DEG);
            if (hdg < 0) hdg += 360 * ONE_DEG;
            h.heading = HEAD_W'(hdg / QTR_DEG);
            h.cx = cx;
            h.cy = cy;
            expected_headings.push_back(h);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic enqueue(input sample_t smp);
        pending_samples.push_back(smp);
        items_queued++;
    endtask

    function automatic logic [SAMPLE_W-1:0] jitter(input int unsigned base,
                                                   input int unsigned bits);
        int off;
        off = int'($urandom & ((32'd1 << bits) - 1));
        if ($urandom_range(0, 1)) off = -off;
        off += int'(base);
        if (off < 0) off = 0;
        if (off > 65535) off = 65535;
        return SAMPLE_W'(off);
    endfunction

    function automatic logic [SAMPLE_W-1:0] corner();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'h7FFF;
            2:       return 16'h8000;
            default: return 16'hFFFF;
        endcase
    endfunction

    task automatic queue_random(input int unsigned count);
        sample_t     smp;
        int unsigned n, reps, kind, mid;
        n = 0;
        while (n < count) begin
            kind = $urandom_range(0, 9);
            reps = 1;
            mid  = $urandom_range(0, 1) ? 32'h7FFF : 32'h8000;
            if (kind < 6) begin
                smp.x = jitter(mid, $urandom_range(1, 16));
                smp.y = jitter(mid, $urandom_range(1, 16));
            end else if (kind < 8) begin
                smp.x = SAMPLE_W'($urandom);
                smp.y = SAMPLE_W'($urandom);
            end else if (kind == 8) begin
                smp.x = corner();
                smp.y = corner();
            end else begin
                // held field so the average settles onto the held sample
                reps  = $urandom_range(6, 12);
                smp.x = $urandom_range(0, 2) != 0 ? corner() : SAMPLE_W'($urandom);
                smp.y = $urandom_range(0, 2) != 0 ? corner() : SAMPLE_W'($urandom);
            end
            repeat (reps) enqueue(smp);
            n += reps;
        end
    endtask

    task automatic wait_drained();
        while (items_taken != items_queued || expected_headings.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_declination(input int deg);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= DECL_W'(deg);
        decl_deg     = DECL_W'(deg);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // item driver
    always @(posedge aclk) begin
        sample_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            drv_gap <= $urandom_range(0, 15);
        end else if (!s_valid || s_ready) begin
            if (drv_gap != 0) begin
                s_valid <= 1'b0;
                drv_gap <= drv_gap - 1;
            end else if (pending_samples.size() != 0) begin
                nxt = pending_samples.pop_front();
                s_valid    <= 1'b1;
                s_sample_x <= nxt.x;
                s_sample_y <= nxt.y;
                drv_gap    <= pause_len(drv_calm);
                if ($urandom_range(0, 31) == 0) drv_calm <= !drv_calm;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result stalls, counted only while a result is waiting
    always @(posedge aclk) begin
        int unsigned w;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rdy_wait <= $urandom_range(0, 15);
        end else if (m_valid && m_ready) begin
            w = pause_len(rdy_calm);
            rdy_wait <= w;
            m_ready  <= (w == 0);
            if ($urandom_range(0, 31) == 0) rdy_calm <= !rdy_calm;
        end else if (rdy_wait != 0) begin
            if (m_valid) begin
                rdy_wait <= rdy_wait - 1;
                m_ready  <= (rdy_wait == 1);
            end
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor: check results, then predict for the item taken this edge
    always @(posedge aclk) begin
        heading_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_headings.size() == 0) begin
                    report_mismatch($sformatf("unexpected result heading %0d",
                                              m_heading_quarter_deg));
                end else begin
                    want = expected_headings.pop_front();
                    if (m_heading_quarter_deg !== want.heading)
                        report_mismatch($sformatf("heading %0d, expected %0d",
                                                  m_heading_quarter_deg, want.heading));
                    if (m_centre_x !== want.cx)
                        report_mismatch($sformatf("centre_x %h, expected %h",
                                                  m_centre_x, want.cx));
                    if (m_centre_y !== want.cy)
                        report_mismatch($sformatf("centre_y %h, expected %h",
                                                  m_centre_y, want.cy));
                end
            end
            if (s_valid && s_ready) begin
                track_sample(sample_t'({s_sample_x, s_sample_y}));
                items_taken++;
            end
        end
    end

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int decl_plan [6];
        decl_plan = '{-180, 180, 255, -256, 0, 1};
        decl_plan[5] = int'($urandom_range(0, 360)) - 180;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        set_declination(90);
        foreach (OPENING[i]) enqueue(sample_t'(OPENING[i]));
        wait_drained();

        foreach (decl_plan[p]) begin
            set_declination(decl_plan[p]);
            queue_random(PHASE_N);
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
src/chcal_pkg.sv
src/compass_heading_with_calibration_unit.sv
sim/compass_heading_with_calibration_unit_tb.sv
